// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro samples on the rising edge of clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while rst_n is low.
`define ABPU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define ABPU_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/abpu_pkg.sv =====
// ----------------------------------------------------------------------------
// abpu_pkg
// Types, constants and helper functions of the ARGB pixel blend unit.
// ----------------------------------------------------------------------------
package abpu_pkg;

  typedef enum logic [1:0] {
    MODE_ADD  = 2'd0,
    MODE_SUB  = 2'd1,
    MODE_MUL  = 2'd2,
    MODE_OVER = 2'd3
  } mode_t;

  localparam logic [7:0] CH_MAX = 8'hFF;

  // Work carried through the division stages. For the arithmetic modes the
  // finished pixel sits in pix and den is zero, so no quotient bit is set.
  // For over, pix holds the alpha byte and the color bytes are built in quo.
  typedef struct packed {
    logic [31:0]      pix;
    logic [15:0]      den;
    logic [2:0][23:0] rem;
    logic [2:0][7:0]  quo;
  } div_t;

  // floor(x / 255) for x up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + {9'h000, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

endpackage

// ===== sv/abpu_front.sv =====
// ----------------------------------------------------------------------------
// abpu_front
// First two pipeline stages: alpha weights and byte products, then the
// arithmetic modes and the numerators and denominator for over.
// ----------------------------------------------------------------------------
module abpu_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_kind,
  input  logic [31:0]       in_pixel_a,
  input  logic [31:0]       in_pixel_b,
  output logic              dn_valid,
  input  logic              dn_stall,
  output abpu_pkg::div_t    dn_data
);

  logic        v1_r;
  logic        v2_r;
  logic        stall1;
  logic        stall2;

  logic [1:0]       kind_r;
  logic [31:0]      pa_r;
  logic [31:0]      pb_r;
  logic [15:0]      wa_r;
  logic [15:0]      wb_r;
  logic [3:0][15:0] prod_r;

  logic [15:0]      wa_nxt;
  logic [15:0]      wb_nxt;
  logic [3:0][15:0] prod_nxt;

  abpu_pkg::div_t   d2_r;
  abpu_pkg::div_t   d2_nxt;

  assign stall2   = v2_r && dn_stall;
  assign stall1   = v1_r && stall2;
  assign in_stall = stall1;
  assign dn_valid = v2_r;
  assign dn_data  = d2_r;

  // Stage one: the two alpha weights and the per-byte products.
  always_comb begin
    wa_nxt = {in_pixel_a[31:24], 8'h00} - {8'h00, in_pixel_a[31:24]};
    wb_nxt = {8'h00, in_pixel_b[31:24]} *
             {8'h00, abpu_pkg::CH_MAX - in_pixel_a[31:24]};
    for (int i = 0; i < 4; i++) begin
      prod_nxt[i] = {8'h00, in_pixel_a[8*i +: 8]} * {8'h00, in_pixel_b[8*i +: 8]};
    end
  end

  // Stage two: finish the arithmetic modes or set up the over division.
  always_comb begin
    logic [16:0] den_sum;
    logic [8:0]  add_sum;
    logic [7:0]  ca;
    logic [7:0]  cb;
    d2_nxt  = '0;
    add_sum = '0;
    ca      = '0;
    cb      = '0;
    den_sum = {1'b0, wa_r} + {1'b0, wb_r};
    unique case (abpu_pkg::mode_t'(kind_r))
      abpu_pkg::MODE_OVER: begin
        d2_nxt.den = den_sum[15:0];
        d2_nxt.pix = {abpu_pkg::div255(den_sum[15:0]), 24'h000000};
        for (int i = 0; i < 3; i++) begin
          d2_nxt.rem[i] = {16'h0000, pa_r[8*i +: 8]} * {8'h00, wa_r} +
                          {16'h0000, pb_r[8*i +: 8]} * {8'h00, wb_r};
        end
      end
      abpu_pkg::MODE_ADD: begin
        for (int i = 0; i < 4; i++) begin
          add_sum = {1'b0, pa_r[8*i +: 8]} + {1'b0, pb_r[8*i +: 8]};
          d2_nxt.pix[8*i +: 8] = add_sum[8] ? abpu_pkg::CH_MAX : add_sum[7:0];
        end
      end
      abpu_pkg::MODE_SUB: begin
        for (int i = 0; i < 4; i++) begin
          ca = pa_r[8*i +: 8];
          cb = pb_r[8*i +: 8];
          d2_nxt.pix[8*i +: 8] = (ca > cb) ? (ca - cb) : 8'h00;
        end
      end
      abpu_pkg::MODE_MUL: begin
        for (int i = 0; i < 4; i++) begin
          d2_nxt.pix[8*i +: 8] = abpu_pkg::div255(prod_r[i]);
        end
      end
      default: d2_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (!stall1) v1_r <= in_valid;
      if (!stall2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !stall1) begin
      kind_r <= in_kind;
      pa_r   <= in_pixel_a;
      pb_r   <= in_pixel_b;
      wa_r   <= wa_nxt;
      wb_r   <= wb_nxt;
      prod_r <= prod_nxt;
    end
    if (v1_r && !stall2) begin
      d2_r <= d2_nxt;
    end
  end

endmodule

// ===== sv/abpu_div_stage.sv =====
// ----------------------------------------------------------------------------
// abpu_div_stage
// One stage of the restoring divider: two quotient bits per color channel.
// ----------------------------------------------------------------------------
module abpu_div_stage #(
  parameter int unsigned TOP_BIT = 7
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_stall,
  input  abpu_pkg::div_t  up_data,
  output logic            dn_valid,
  input  logic            dn_stall,
  output abpu_pkg::div_t  dn_data
);

  logic            v_r;
  abpu_pkg::div_t  d_r;
  abpu_pkg::div_t  d_nxt;

  assign up_stall = v_r && dn_stall;
  assign dn_valid = v_r;
  assign dn_data  = d_r;

  // A zero denominator never takes a step, which leaves the color at zero.
  always_comb begin
    logic [23:0] dsh;
    d_nxt = up_data;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 2; k++) begin
        dsh = {8'h00, up_data.den} << (TOP_BIT - k);
        if ((up_data.den != 16'h0000) && (d_nxt.rem[i] >= dsh)) begin
          d_nxt.rem[i]               = d_nxt.rem[i] - dsh;
          d_nxt.quo[i][TOP_BIT - k]  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (!up_stall) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && !up_stall) begin
      d_r <= d_nxt;
    end
  end

endmodule

// ===== sv/argb_pixel_blend_unit.sv =====
// Each input goes through the front stages, then the divider stages.
// Throughput: one pixel pair per cycle while in_stall is low; the four
// quotient bit pairs of the over divider each have a pipeline stage of
// their own. A stall holds only the stages that cannot move; empty stages
// still fill. Reset (rst_n low, synchronous) clears the stage valid bits only.
// ----------------------------------------------------------------------------
// argb_pixel_blend_unit
// Blends two ARGB8888 pixels by add, subtract, multiply or over.
// ----------------------------------------------------------------------------
module argb_pixel_blend_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_pixel_a,
  input  logic [31:0] in_pixel_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_pixel_out
);

  localparam int unsigned NSTG = 4;

  logic [NSTG:0]             v;
  logic [NSTG:0]             s;
  abpu_pkg::div_t [NSTG:0]   d;

  abpu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_kind    (in_kind),
    .in_pixel_a (in_pixel_a),
    .in_pixel_b (in_pixel_b),
    .dn_valid   (v[0]),
    .dn_stall   (s[0]),
    .dn_data    (d[0])
  );

  for (genvar g = 0; g < NSTG; g++) begin : g_div
    abpu_div_stage #(
      .TOP_BIT (7 - 2 * g)
    ) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (v[g]),
      .up_stall (s[g]),
      .up_data  (d[g]),
      .dn_valid (v[g+1]),
      .dn_stall (s[g+1]),
      .dn_data  (d[g+1])
    );
  end

  assign s[NSTG]       = out_stall;
  assign out_valid     = v[NSTG];
  assign out_pixel_out = d[NSTG].pix | {8'h00, d[NSTG].quo[2], d[NSTG].quo[1], d[NSTG].quo[0]};

endmodule

// ===== sv/abpu_checker.sv =====
// ----------------------------------------------------------------------------
// abpu_checker
// Port-level checks of the blend unit, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module abpu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_pixel_out
);

  // A stalled result stays valid and unchanged.
  `ABPU_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_pixel_out), "stalled result changed")

  // The input side is held back only when a result waits at the output.
  `ABPU_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled without output stall")

  // Reset empties the pipeline.
  `ABPU_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind argb_pixel_blend_unit abpu_checker u_abpu_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the ARGB pixel blend unit against its own pixel blend predictor.
// Directed pixel pairs cover the channel extremes, every blend mode, the
// saturation and clamping edges, and over with zero, full and partial
// coverage. They are followed by random pixel pairs that lean toward the
// extreme byte values. The sender works in bursts, the receiver stalls on
// changing patterns, and every result is checked in order against the
// predicted pixels.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CHAN_FULL    = 255;
  localparam int          RANDOM_JOBS  = 1650;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          LIMIT_CYCLES = 400000;

  typedef struct {
    abpu_pkg::mode_t kind;
    logic [31:0]     pixel_a;
    logic [31:0]     pixel_b;
    bit              wait_drain;
  } blend_job_t;

  typedef enum int {
    FLOW_FREE,
    FLOW_RANDOM,
    FLOW_PERIODIC,
    FLOW_HEAVY
  } flow_style_t;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind       = '0;
  logic [31:0] in_pixel_a    = '0;
  logic [31:0] in_pixel_b    = '0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [31:0] out_pixel_out;

  blend_job_t  job_q[$];
  logic [31:0] blended_q[$];
  blend_job_t  next_job;
  int          accepted_count = 0;
  int          received_count = 0;
  int          mismatch_count = 0;
  int          burst_left     = 0;
  int          gap_left       = 0;
  int          cycle_count    = 0;
  int          stall_phase    = 0;
  flow_style_t stall_style    = FLOW_FREE;

  argb_pixel_blend_unit DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_pixel_a    (in_pixel_a),
    .in_pixel_b    (in_pixel_b),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_out (out_pixel_out)
  );

  always #6 clk = ~clk;

  // Expected blended pixel for one pixel pair.
  function automatic logic [31:0] blend_pixel(input abpu_pkg::mode_t kind,
                                              input logic [31:0] pa,
                                              input logic [31:0] pb);
    logic [31:0] result;
    int unsigned alpha_a, alpha_b, weight_a, weight_b, coverage, num, chan, x, y;
    result = '0;
    if (kind == abpu_pkg::MODE_OVER) begin
      alpha_a  = 32'(pa[31:24]);
      alpha_b  = 32'(pb[31:24]);
      weight_a = alpha_a * CHAN_FULL;
      weight_b = alpha_b * (CHAN_FULL - alpha_a);
      coverage = weight_a + weight_b;
      result[31:24] = 8'(coverage / CHAN_FULL);
      for (int i = 0; i < 3; i++) begin
        x    = 32'(pa[8*i +: 8]);
        y    = 32'(pb[8*i +: 8]);
        num  = x * weight_a + y * weight_b;
        chan = (coverage != 0) ? num / coverage : 0;
        if (chan > CHAN_FULL) chan = CHAN_FULL;
        result[8*i +: 8] = 8'(chan);
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        x = 32'(pa[8*i +: 8]);
        y = 32'(pb[8*i +: 8]);
        unique case (kind)
          abpu_pkg::MODE_ADD: begin
            chan = (x + y > CHAN_FULL) ? CHAN_FULL : x + y;
          end
          abpu_pkg::MODE_SUB: begin
            chan = (x > y) ? x - y : 0;
          end
          default: begin
            chan = (x * y) / CHAN_FULL;
          end
        endcase
        result[8*i +: 8] = 8'(chan);
      end
    end
    return result;
  endfunction

  // Bytes lean toward the extremes so that saturation and clamping are hit often.
  function automatic logic [7:0] rand_byte();
    unique case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h01;
      3: return 8'hFE;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_pixel();
    if ($urandom_range(0, 1) == 0) return $urandom;
    return {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
  endfunction

  function automatic void add_job(input abpu_pkg::mode_t kind, input logic [31:0] pa,
                                  input logic [31:0] pb, input bit wait_drain);
    blend_job_t job;
    job.kind       = kind;
    job.pixel_a    = pa;
    job.pixel_b    = pb;
    job.wait_drain = wait_drain;
    job_q.push_back(job);
  endfunction

  // Sender: bursts of transfers with random gaps; some jobs wait for an empty pipe.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        blended_q.push_back(blend_pixel(abpu_pkg::mode_t'(in_kind), in_pixel_a, in_pixel_b));
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (job_q.size() != 0 &&
                     (!job_q[0].wait_drain || accepted_count == received_count)) begin
          next_job = job_q.pop_front();
          burst_left--;
          in_valid   <= 1'b1;
          in_kind    <= next_job.kind;
          in_pixel_a <= next_job.pixel_a;
          in_pixel_b <= next_job.pixel_b;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern switches style now and then.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      stall_phase++;
      if (($urandom & 63) == 0) stall_style = flow_style_t'($urandom_range(0, 3));
      unique case (stall_style)
        FLOW_FREE:     out_stall <= 1'b0;
        FLOW_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
        FLOW_PERIODIC: out_stall <= stall_phase[2];
        default:       out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Monitor: every result transfer is compared with the oldest expected pixel.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (blended_q.size() == 0) begin
        $error("pixel_out: expected nothing, actual %h", out_pixel_out);
        mismatch_count++;
      end else if (out_pixel_out !== blended_q[0]) begin
        $error("pixel_out: expected %h, actual %h", blended_q[0], out_pixel_out);
        mismatch_count++;
        void'(blended_q.pop_front());
      end else begin
        void'(blended_q.pop_front());
      end
      received_count <= received_count + 1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    // Channel extremes under every mode.
    for (int m = 0; m < 4; m++) begin
      add_job(abpu_pkg::mode_t'(m), 32'h0000_0000, 32'h0000_0000, 1'b0);
      add_job(abpu_pkg::mode_t'(m), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      add_job(abpu_pkg::mode_t'(m), 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
      add_job(abpu_pkg::mode_t'(m), 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    end
    // Saturating add and clamping subtract on mixed channels.
    add_job(abpu_pkg::MODE_ADD, 32'h80C0_F001, 32'h9040_5002, 1'b0);
    add_job(abpu_pkg::MODE_SUB, 32'h1020_3040, 32'h2010_1050, 1'b0);
    add_job(abpu_pkg::MODE_MUL, 32'h8080_8080, 32'hFFFF_FFFF, 1'b0);
    // Over: zero coverage with color, opaque source, clear source, partial alphas.
    add_job(abpu_pkg::MODE_OVER, 32'h0012_3456, 32'h00AB_CDEF, 1'b0);
    add_job(abpu_pkg::MODE_OVER, 32'hFF10_2030, 32'h80A0_B0C0, 1'b0);
    add_job(abpu_pkg::MODE_OVER, 32'h0010_2030, 32'hFFA0_B0C0, 1'b0);
    add_job(abpu_pkg::MODE_OVER, 32'h80FF_0080, 32'h4000_FF7F, 1'b0);
    add_job(abpu_pkg::MODE_OVER, 32'h01FF_FFFF, 32'h0100_0000, 1'b0);

    for (int n = 0; n < RANDOM_JOBS; n++)
      add_job(abpu_pkg::mode_t'($urandom_range(0, 3)), rand_pixel(), rand_pixel(),
              n == 0 || $urandom_range(0, 299) == 0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (job_q.size() != 0 || in_valid || blended_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && blended_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== argb_pixel_blend_unit.f =====
+incdir+sv
sv/abpu_pkg.sv
sv/abpu_front.sv
sv/abpu_div_stage.sv
sv/argb_pixel_blend_unit.sv
sv/abpu_checker.sv
tb/testbench.sv
